// File: design/complex_arithmetic_unit_defines.svh
// Assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Implication checked at every rising clock edge while out of reset
`define CAU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent
`define CAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, operation codes and the pipeline depth.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    localparam int DW     = 16;
    localparam int FB     = 8;
    localparam int PW     = 2 * DW;          // product magnitude width
    localparam int SW     = PW + 1;          // sum of two products
    localparam int QW     = DW + 2;          // quotient width before clamp
    localparam int NSTEP  = SW - 1 + FB + 1; // quotient bits produced
    localparam int DEPTH  = NSTEP + 3;       // pipeline stages

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

endpackage

`default_nettype wire

// File: design/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined complex add, subtract, multiply and divide in signed Q8.8.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis: one request per beat, tdata holds mode, a_re,
//   a_im, b_re, b_im. Master channel m_axis: one result per request, tdata
//   holds res_re, res_im, saturated, div_by_zero.
//   Throughput is one request per cycle while the receiver does not stall.
//   The pipeline depth at Q8.8 is set by the restoring divider: one
//   quotient bit per stage over the 33-bit numerator plus eight fraction
//   bits, behind a product stage and a sum and denominator stage,
//   followed by a clamp stage.
//   All operations go through the same stages, so order is kept.
//   Reset clears every stage valid bit; the payload is not reset.
//   When the receiver stalls on a waiting result, the whole pipeline holds
//   and s_axis_tready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [71:0] s_axis_tdata,   // mode[1:0], a_re, a_im, b_re, b_im, zero pad
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // res_re, res_im, saturated, div_by_zero, pad
);

    typedef struct packed {
        logic          div;
        logic          dz;
        logic          nre;
        logic          nim;
        logic [SW-1:0] nu_re;   // numerator (real); the remainder is kept in r_rem_re
        logic [SW-1:0] nu_im;
        logic [QW-1:0] q_re;
        logic [QW-1:0] q_im;
        logic [PW:0]   den;
    } t_stg;

    logic       adv;
    logic [DEPTH-1:0] r_vld;
    t_stg       r_st [NSTEP+1];
    t_stg       n_st [NSTEP+1];

    // Stage 0 registers: mode, product signs, four products, two squares, add/sub sums
    logic [1:0]    r_mode;
    logic          r_sa [4];
    logic [PW-1:0] r_p  [4];   // ar*br, ai*bi, ai*br, ar*bi
    logic [DW:0]   r_sumre, r_sumim;
    logic [PW-1:0] r_sqr, r_sqi;

    logic signed [DW-1:0] ar, ai, br, bi;
    logic [DW-1:0] mar, mai, mbr, mbi;
    logic [1:0]    i_mode;

    assign i_mode = s_axis_tdata[1:0];
    assign ar = s_axis_tdata[2+:DW];
    assign ai = s_axis_tdata[2+DW+:DW];
    assign br = s_axis_tdata[2+2*DW+:DW];
    assign bi = s_axis_tdata[2+3*DW+:DW];
    assign mar = ar[DW-1] ? DW'(-ar) : ar;
    assign mai = ai[DW-1] ? DW'(-ai) : ai;
    assign mbr = br[DW-1] ? DW'(-br) : br;
    assign mbi = bi[DW-1] ? DW'(-bi) : bi;

    assign adv = !r_vld[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mode  <= i_mode;
            r_sa[0] <= ar[DW-1] ^ br[DW-1];
            r_sa[1] <= ai[DW-1] ^ bi[DW-1];
            r_sa[2] <= ai[DW-1] ^ br[DW-1];
            r_sa[3] <= ar[DW-1] ^ bi[DW-1];
            r_p[0]  <= PW'(mar) * PW'(mbr);
            r_p[1]  <= PW'(mai) * PW'(mbi);
            r_p[2]  <= PW'(mai) * PW'(mbr);
            r_p[3]  <= PW'(mar) * PW'(mbi);
            r_sqr   <= PW'(mbr) * PW'(mbr);
            r_sqi   <= PW'(mbi) * PW'(mbi);
            if (i_mode == OP_ADD) begin
                r_sumre <= (DW+1)'(signed'(ar)) + (DW+1)'(signed'(br));
                r_sumim <= (DW+1)'(signed'(ai)) + (DW+1)'(signed'(bi));
            end else begin
                r_sumre <= (DW+1)'(signed'(ar)) - (DW+1)'(signed'(br));
                r_sumim <= (DW+1)'(signed'(ai)) - (DW+1)'(signed'(bi));
            end
        end
    end

    // signed-magnitude add of two products
    function automatic logic [SW:0] sm_add(input logic n1, input logic [PW-1:0] m1,
                                           input logic n2, input logic [PW-1:0] m2);
        logic [SW-1:0] m;
        logic          n;
        begin
            if (n1 == n2) begin
                m = SW'(m1) + SW'(m2);
                n = n1;
            end else if (m1 >= m2) begin
                m = SW'(m1 - m2);
                n = n1;
            end else begin
                m = SW'(m2 - m1);
                n = n2;
            end
            if (m == '0) n = 1'b0;
            return {n, m};
        end
    endfunction

    // Stage 1: combine products, or pass the add/sub sum as a magnitude; form the denominator
    logic [SW:0] c_re, c_im;
    logic        mul_op, div_op;
    assign mul_op = (r_mode == OP_MUL);
    assign div_op = (r_mode == OP_DIV);

    always_comb begin
        case (r_mode)
            OP_MUL: begin
                c_re = sm_add(r_sa[0], r_p[0], !r_sa[1], r_p[1]);
                c_im = sm_add(r_sa[2], r_p[2], r_sa[3], r_p[3]);
            end
            OP_DIV: begin
                c_re = sm_add(r_sa[0], r_p[0], r_sa[1], r_p[1]);
                c_im = sm_add(r_sa[2], r_p[2], !r_sa[3], r_p[3]);
            end
            default: begin
                c_re = {r_sumre[DW], SW'(r_sumre[DW] ? (DW+1)'(-r_sumre) : r_sumre)};
                c_im = {r_sumim[DW], SW'(r_sumim[DW] ? (DW+1)'(-r_sumim) : r_sumim)};
            end
        endcase
    end

    always_comb begin
        n_st[0]       = r_st[0];
        n_st[0].div   = div_op;
        n_st[0].den   = (PW+1)'(r_sqr) + (PW+1)'(r_sqi);
        n_st[0].dz    = div_op && (r_sqr == '0) && (r_sqi == '0);
        n_st[0].nre   = c_re[SW];
        n_st[0].nim   = c_im[SW];
        n_st[0].q_re  = '0;
        n_st[0].q_im  = '0;
        if (mul_op) begin
            n_st[0].nu_re = c_re[SW-1:0] >> FB;
            n_st[0].nu_im = c_im[SW-1:0] >> FB;
        end else begin
            n_st[0].nu_re = c_re[SW-1:0];
            n_st[0].nu_im = c_im[SW-1:0];
        end
    end

    // Divider stages: one quotient bit each, numerator bits taken MSB first.
    // The partial remainders travel in their own registers beside each stage.
    logic [PW:0] r_rem_re [NSTEP+1];
    logic [PW:0] r_rem_im [NSTEP+1];

    genvar g;
    generate
        for (g = 1; g <= NSTEP; g++) begin : g_div
            logic [PW+1:0] t_re, t_im, d;
            logic          b_re, b_im, ge_re, ge_im;
            always_comb begin
                d    = {1'b0, r_st[g-1].den};
                b_re = (g <= SW) ? r_st[g-1].nu_re[SW-1] : 1'b0;
                b_im = (g <= SW) ? r_st[g-1].nu_im[SW-1] : 1'b0;
                t_re = {r_rem_re[g-1], b_re};
                t_im = {r_rem_im[g-1], b_im};
                ge_re = t_re >= d;
                ge_im = t_im >= d;
                n_st[g]       = r_st[g-1];
                n_st[g].nu_re = r_st[g-1].nu_re << 1;
                n_st[g].nu_im = r_st[g-1].nu_im << 1;
                // hold the quotient once its top bit is set, which lies beyond the clamp range
                n_st[g].q_re  = r_st[g-1].q_re[QW-1] ? r_st[g-1].q_re
                              : {r_st[g-1].q_re[QW-2:0], ge_re};
                n_st[g].q_im  = r_st[g-1].q_im[QW-1] ? r_st[g-1].q_im
                              : {r_st[g-1].q_im[QW-2:0], ge_im};
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_st[g]     <= n_st[g];
                    r_rem_re[g] <= (PW+1)'(ge_re ? t_re - d : t_re);
                    r_rem_im[g] <= (PW+1)'(ge_im ? t_im - d : t_im);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st[0]     <= n_st[0];
            r_rem_re[0] <= '0;
            r_rem_im[0] <= '0;
        end
    end

    localparam int L = NSTEP;

    // non-divide magnitudes bypass the divider chain in a delay line
    logic [SW-1:0] r_bp_re [NSTEP+1];
    logic [SW-1:0] r_bp_im [NSTEP+1];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_bp_re[0] <= n_st[0].nu_re;
            r_bp_im[0] <= n_st[0].nu_im;
            for (int k = 1; k <= NSTEP; k++) begin
                r_bp_re[k] <= r_bp_re[k-1];
                r_bp_im[k] <= r_bp_im[k-1];
            end
        end
    end

    // Final stage: pick magnitude, clamp, zero the result on divide by zero, pack
    logic [DW-1:0] r_ore, r_oim;
    logic          r_sat, r_dz;
    logic [SW-1:0] m_re, m_im;
    logic          mn_re, mn_im, ms_re, ms_im;
    logic [DW-1:0] mo_re, mo_im;
    always_comb begin
        m_re  = r_st[L].div ? SW'(r_st[L].q_re) : r_bp_re[L];
        m_im  = r_st[L].div ? SW'(r_st[L].q_im) : r_bp_im[L];
        mn_re = r_st[L].nre && (m_re != '0);
        mn_im = r_st[L].nim && (m_im != '0);
        ms_re = m_re > (mn_re ? SW'(1) << (DW-1) : (SW'(1) << (DW-1)) - SW'(1));
        ms_im = m_im > (mn_im ? SW'(1) << (DW-1) : (SW'(1) << (DW-1)) - SW'(1));
        mo_re = ms_re ? (mn_re ? {1'b1, (DW-1)'(0)} : {1'b0, {(DW-1){1'b1}}})
                      : DW'(mn_re ? -m_re : m_re);
        mo_im = ms_im ? (mn_im ? {1'b1, (DW-1)'(0)} : {1'b0, {(DW-1){1'b1}}})
                      : DW'(mn_im ? -m_im : m_im);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_st[L].dz) begin
                r_ore <= '0; r_oim <= '0; r_sat <= 1'b0;
            end else begin
                r_ore <= mo_re; r_oim <= mo_im; r_sat <= ms_re | ms_im;
            end
            r_dz <= r_st[L].dz;
        end
    end

    assign m_axis_tvalid = r_vld[DEPTH-1];
    assign m_axis_tdata  = {6'd0, r_dz, r_sat, r_oim, r_ore};

    `CAU_ASSERT_IMP(a_dz_zero, m_axis_tvalid && m_axis_tdata[33],
                    m_axis_tdata[31:0] == 32'd0 && !m_axis_tdata[32])
    `CAU_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))
    `CAU_ASSERT_IMP(a_ready, !m_axis_tvalid, s_axis_tready)

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Streams complex operand requests through the unit with random stalls on
// both channels and checks every result against a fixed-point predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import cau_pkg::*;
();

    typedef struct packed {
        logic [15:0] b_im;
        logic [15:0] b_re;
        logic [15:0] a_im;
        logic [15:0] a_re;
        logic [1:0]  mode;
    } t_req;

    typedef struct {
        logic [15:0] re;
        logic [15:0] im;
        logic        sat;
        logic        dz;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    t_req   pending_reqs[$];
    t_res   expected_results[$];
    int     n_errors = 0;
    int     rx_gap = 0;
    int     rx_hold = 0;
    int     tx_gap = 0;
    bit     tx_calm = 0;
    bit     drain_pause = 0;
    bit     stim_done = 0;
    longint n_cycles = 0;

    complex_arithmetic_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Truncated magnitude, sign and saturation to one 16-bit part.
    function automatic logic [15:0] clamp_part(input bit neg, input logic [63:0] mag,
                                               inout logic sat);
        logic [63:0] lim;
        lim = neg ? 64'd32768 : 64'd32767;
        if (mag > lim) begin
            mag = lim;
            sat = 1;
        end
        return neg ? 16'(-mag) : 16'(mag);
    endfunction

    function automatic logic [63:0] mag_of(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // floor(num * 2^8 / den), large quotients capped above range.
    function automatic logic [63:0] scaled_quotient(input logic [63:0] num,
                                                    input logic [63:0] den);
        logic [63:0] q;
        q = num / den;
        if (q > 64'd32768) q = 64'd32769;
        return (q << FB) | (((num % den) << FB) / den);
    endfunction

    function automatic t_res complex_result(input t_req r);
        t_res   o;
        longint ar, ai, br, bi, re, im;
        logic [63:0] den;
        o = '{re: '0, im: '0, sat: 0, dz: 0};
        ar = longint'($signed(r.a_re));
        ai = longint'($signed(r.a_im));
        br = longint'($signed(r.b_re));
        bi = longint'($signed(r.b_im));
        case (r.mode)
            OP_ADD, OP_SUB: begin
                re = (r.mode == OP_ADD) ? ar + br : ar - br;
                im = (r.mode == OP_ADD) ? ai + bi : ai - bi;
                o.re = clamp_part(re < 0, mag_of(re), o.sat);
                o.im = clamp_part(im < 0, mag_of(im), o.sat);
            end
            OP_MUL: begin
                re = ar * br - ai * bi;
                im = ai * br + ar * bi;
                o.re = clamp_part(re < 0 && (mag_of(re) >> FB) != 0, mag_of(re) >> FB, o.sat);
                o.im = clamp_part(im < 0 && (mag_of(im) >> FB) != 0, mag_of(im) >> FB, o.sat);
            end
            default: begin
                den = 64'(br * br + bi * bi);
                if (den == 0) begin
                    o.dz = 1;
                end else begin
                    re = ar * br + ai * bi;
                    im = ai * br - ar * bi;
                    o.re = clamp_part(re < 0 && scaled_quotient(mag_of(re), den) != 0,
                                      scaled_quotient(mag_of(re), den), o.sat);
                    o.im = clamp_part(im < 0 && scaled_quotient(mag_of(im), den) != 0,
                                      scaled_quotient(mag_of(im), den), o.sat);
                end
            end
        endcase
        return o;
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 1024)) - 512);
            4: return $urandom_range(0, 1) ? 16'h0100 : 16'hff00;
            default: return 16'($urandom);
        endcase
    endfunction

    // Stimulus: directed corners and cases first, then random requests.
    initial begin
        t_req r;
        logic [15:0] corners[4];
        corners = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001};
        for (int m = 0; m < 4; m++) begin
            for (int k = 0; k < 4; k++) begin
                r.mode = 2'(m);
                r.a_re = corners[k];
                r.a_im = corners[3 - k];
                r.b_re = corners[(k + 1) % 4];
                r.b_im = corners[(k + 2) % 4];
                pending_reqs.push_back(r);
            end
        end
        // divide by zero, plain divide, negative product toward zero, full-scale multiply, negative quotient
        pending_reqs.push_back('{16'h0000, 16'h0000, 16'h0300, 16'h0500, OP_DIV});
        pending_reqs.push_back('{16'h0100, 16'h0100, 16'h0100, 16'h0000, OP_DIV});
        pending_reqs.push_back('{16'h0000, 16'hffff, 16'h0000, 16'h0001, OP_MUL});
        pending_reqs.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000, OP_MUL});
        pending_reqs.push_back('{16'h0000, 16'h0003, 16'hfff9, 16'h0000, OP_DIV});
        for (int n = 0; n < 1800; n++) begin
            r.mode = 2'($urandom);
            r.a_re = rand_word();
            r.a_im = rand_word();
            r.b_re = rand_word();
            r.b_im = $urandom_range(0, 30) == 0 ? 16'h0000 : rand_word();
            if (r.mode == OP_DIV && $urandom_range(0, 20) == 0) begin
                r.b_re = 0;
                r.b_im = 0;
            end
            pending_reqs.push_back(r);
        end
    end

    // Driver
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(complex_result(t_req'(s_axis_tdata[65:0])));
                if (pending_reqs.size() == 0) stim_done <= 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                // pause once mid-run until the pipeline drains
                if (pending_reqs.size() == 1000 && !drain_pause) begin
                    drain_pause <= 1;
                    s_axis_tvalid <= 0;
                end else if (drain_pause && pending_reqs.size() == 1000
                             && expected_results.size() != 0) begin
                    s_axis_tvalid <= 0;
                end else if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    s_axis_tvalid <= 0;
                end else if (pending_reqs.size() != 0) begin
                    if (!tx_calm && pending_reqs.size() > 200 && $urandom_range(0, 7) == 0) begin
                        tx_gap <= $urandom_range(0, 5);
                        s_axis_tvalid <= 0;
                    end else begin
                        s_axis_tdata  <= {8'h00, pending_reqs.pop_front()};
                        s_axis_tvalid <= 1;
                    end
                end else begin
                    s_axis_tvalid <= 0;
                end
            end
            tx_calm <= (n_cycles / 1000) % 3 == 2;
        end
    end

    // Monitor and receiver stalls
    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.re  = m_axis_tdata[15:0];
                got.im  = m_axis_tdata[31:16];
                got.sat = m_axis_tdata[32];
                got.dz  = m_axis_tdata[33];
                if (expected_results.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.re !== want.re) begin
                        $error("res_re expected %h got %h", want.re, got.re);
                        n_errors++;
                    end
                    if (got.im !== want.im) begin
                        $error("res_im expected %h got %h", want.im, got.im);
                        n_errors++;
                    end
                    if (got.sat !== want.sat) begin
                        $error("saturated expected %b got %b", want.sat, got.sat);
                        n_errors++;
                    end
                    if (got.dz !== want.dz) begin
                        $error("div_by_zero expected %b got %b", want.dz, got.dz);
                        n_errors++;
                    end
                end
            end
            // long hold-off early on so the pipeline fills and backpressures
            if (rx_hold < 120 && n_cycles > 150) begin
                rx_hold <= rx_hold + 1;
                m_axis_tready <= 0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                m_axis_tready <= 0;
            end else if (pending_reqs.size() > 200 && $urandom_range(0, 7) == 0) begin
                rx_gap <= $urandom_range(0, 5);
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    initial begin
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        m_axis_tready = 0;
        i_rst_n = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        wait (stim_done && expected_results.size() == 0);
        repeat (2 * DEPTH) @(posedge i_clk);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+design
design/cau_pkg.sv
design/complex_arithmetic_unit.sv
bench/tb.sv
